// ===== hw/rtl/fpra_pkg.sv =====
// Shared types and helpers for the first-fit page run allocator.
// No dependencies; imported by fpra_tag_ram, fpra_scan and the top level.
`default_nettype none

package fpra_pkg;

    // Register map, byte addresses
    localparam logic [2:0] REG_REGION_BASE = 3'd0;

    // Width of one page tag
    localparam int TAG_W = 8;

    // One result word
    typedef struct packed {
        logic        granted;
        logic [31:0] run_address;
        logic [7:0]  first_page;
        logic [7:0]  run_tag;
    } t_result;

    // Tag sequence: 1..255, then back to 1, never 0
    function automatic logic [TAG_W-1:0] next_tag(input logic [TAG_W-1:0] t);
        return (t == 8'hFF) ? 8'd1 : t + 8'd1;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fpra_tag_ram.sv =====
// Page tag memory: one write port, one read port, registered read data.
// Depends on fpra_pkg for the tag width.
`default_nettype none

module fpra_tag_ram
    import fpra_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [TAG_W-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [TAG_W-1:0] o_rd_data
);

    logic [TAG_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fpra_scan.sv =====
// Sequencer: clears the tag memory after reset, scans first-fit for a free run,
// marks it with a fresh tag and builds the result. Depends on fpra_pkg.
`default_nettype none

module fpra_scan
    import fpra_pkg::*;
#(
    parameter int PAGE_COUNT = 256,
    parameter int PAGE_BYTES = 4096,
    parameter int AW         = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request side
    input  wire logic             i_req_valid,
    input  wire logic [8:0]       i_req_pages,
    output logic                  o_req_ready,
    input  wire logic [31:0]      i_region_base,
    // result side
    output logic                  o_res_valid,
    output t_result               o_res,
    input  wire logic             i_res_ready,
    // tag memory
    output logic                  o_wr_en,
    output logic      [AW-1:0]    o_wr_addr,
    output logic      [TAG_W-1:0] o_wr_data,
    output logic                  o_rd_en,
    output logic      [AW-1:0]    o_rd_addr,
    input  wire logic [TAG_W-1:0] i_rd_data
);

    localparam int SW = $clog2(PAGE_COUNT + 1);
    localparam int CW = (SW > 9) ? SW : 9;
    localparam logic [AW-1:0] LAST_IDX = AW'(PAGE_COUNT - 1);
    localparam logic [31:0]   PB       = 32'(PAGE_BYTES);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_NEIGH = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_idx, n_idx;
    logic [SW-1:0]    r_streak, n_streak;
    logic [8:0]       r_want, n_want;
    logic [TAG_W-1:0] r_prev, n_prev;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [AW-1:0]    r_start, n_start;
    logic [AW-1:0]    r_end, n_end;
    logic             r_at_edge, n_at_edge;
    logic [31:0]      r_offset, n_offset;
    t_result          r_res, n_res;

    logic [CW-1:0]    streak_inc;
    logic [TAG_W-1:0] neigh_next;
    logic [TAG_W-1:0] tag_a;

    assign streak_inc = CW'(r_streak) + CW'(1);
    assign neigh_next = r_at_edge ? '0 : i_rd_data;
    assign tag_a      = next_tag(r_prev);

    // Next-state and datapath
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_streak  = r_streak;
        n_want    = r_want;
        n_prev    = r_prev;
        n_tag     = r_tag;
        n_start   = r_start;
        n_end     = r_end;
        n_at_edge = r_at_edge;
        n_offset  = r_offset;
        n_res     = r_res;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_data = r_tag;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx + AW'(1);

        unique case (r_state)
            ST_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_data = '0;
                n_idx     = r_idx + AW'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                    n_idx   = '0;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_rd_addr   = '0;
                if (i_req_valid) begin
                    o_rd_en  = 1'b1;
                    n_idx    = '0;
                    n_streak = '0;
                    n_prev   = '0;
                    n_want   = (i_req_pages == 9'd0) ? 9'd1 : i_req_pages;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // data of page r_idx arrives; fetch the following page meanwhile
                o_rd_en = (r_idx != LAST_IDX);
                n_idx   = r_idx + AW'(1);
                if (i_rd_data != '0) begin
                    n_streak = '0;
                    n_prev   = i_rd_data;
                end else begin
                    n_streak = SW'(streak_inc);
                end
                if ((i_rd_data == '0) && (streak_inc >= CW'(r_want))) begin
                    n_start   = r_idx - AW'(r_streak);
                    n_end     = r_idx;
                    n_at_edge = (r_idx == LAST_IDX);
                    n_state   = ST_NEIGH;
                end else if (r_idx == LAST_IDX) begin
                    n_res   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_NEIGH: begin
                // tag differs from both neighbours
                n_tag    = (tag_a == neigh_next) ? next_tag(tag_a) : tag_a;
                n_offset = 32'({{(32-AW){1'b0}}, r_start} * PB);
                n_idx    = r_start;
                n_state  = ST_WRITE;
            end
            ST_WRITE: begin
                o_wr_en = 1'b1;
                n_idx   = r_idx + AW'(1);
                if (r_idx == r_end) begin
                    n_res.granted     = 1'b1;
                    n_res.run_address = i_region_base + r_offset;
                    n_res.first_page  = 8'(r_start);
                    n_res.run_tag     = r_tag;
                    n_state           = ST_DONE;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_streak  <= n_streak;
        r_want    <= n_want;
        r_prev    <= n_prev;
        r_tag     <= n_tag;
        r_start   <= n_start;
        r_end     <= n_end;
        r_at_edge <= n_at_edge;
        r_offset  <= n_offset;
        r_res     <= n_res;
    end

    // The streak only counts pages already passed
    a_streak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (AW'(r_streak) <= r_idx))
        else $error("free streak longer than scanned pages");

    // Marking stays inside the run
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> (r_idx >= r_start && r_idx <= r_end))
        else $error("run write outside the found run");

    // A marked page never gets the free tag
    a_tag_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> (o_wr_data != '0))
        else $error("run marked with zero tag");

    // A refused request carries an all-zero result
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_res.granted) |->
            (r_res.run_address == '0 && r_res.run_tag == '0 && r_res.first_page == '0))
        else $error("refused result not zero");

    // A granted result has a nonzero tag
    a_grant_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_res.granted) |-> (r_res.run_tag != '0))
        else $error("granted result with zero tag");

endmodule

`default_nettype wire

// ===== hw/rtl/first_fit_page_run_allocator.sv =====
// First-fit contiguous page run allocator, top level.
// Instantiates fpra_tag_ram and fpra_scan; uses fpra_pkg.
//
// Usage:
//   Input stream (s_axis): one word per request, tdata[8:0] = request_pages.
//   A request for 0 pages is served as a request for 1.
//   Output stream (m_axis): one word per request. tuser[0] = granted,
//   tdata = run_address, first_page, run_tag. Refused requests return zeros.
//   APB port: register region_base at byte address 0, to be written only while idle; the block does not enforce this.
// Timing:
//   After reset the tag memory is cleared, one page a cycle; the input is not
//   ready during that pass. A request is started from the idle state; the
//   scan then reads the pages in order up to the end of the found run (at
//   most PAGE_COUNT), the neighbour tag is chosen, the run is marked page by
//   page, and the result is handed to the output register. The single read
//   port of the tag memory, one page per cycle, limits the scan.
//   One request is in work at a time. The output register holds a result
//   while the receiver stalls; the next request runs meanwhile and waits
//   with its result until the register is free.
`default_nettype none

module first_fit_page_run_allocator
    import fpra_pkg::*;
#(
    parameter int PAGE_COUNT = 256,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [8:0] request_pages, [15:9] zero
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [47:0] o_m_axis_tdata,   // [31:0] run_address, [39:32] first_page,
                                               // [47:40] run_tag
    output logic      [0:0]  o_m_axis_tuser,   // [0] granted
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(PAGE_COUNT);

    logic [31:0]      r_region_base;
    logic             r_out_valid;
    t_result          r_out;

    logic             res_valid;
    t_result          res;
    logic             out_free;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [TAG_W-1:0] wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [TAG_W-1:0] rd_data;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_REGION_BASE) ? r_region_base : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= '0;
        end else if (psel && penable && pwrite && (paddr == REG_REGION_BASE)) begin
            r_region_base <= pwdata;
        end
    end

    fpra_tag_ram #(
        .DEPTH (PAGE_COUNT),
        .AW    (AW)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fpra_scan #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES),
        .AW         (AW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .i_req_pages   (i_s_axis_tdata[8:0]),
        .o_req_ready   (o_s_axis_tready),
        .i_region_base (r_region_base),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_ready   (out_free),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    // Output register
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.run_tag, r_out.first_page, r_out.run_address};
    assign o_m_axis_tuser  = r_out.granted;

endmodule

`default_nettype wire
